// ===== src/jmfe_pkg.sv =====
`timescale 1ns / 1ps
package jmfe_pkg;

  localparam int LEN_W         = 32;
  localparam int MAX_RES       = 3;
  localparam int RES_CNT_W     = 2;
  localparam int RES_IDX_W     = 2;

  localparam logic [7:0]       MARK_FF       = 8'hFF;
  localparam logic [7:0]       MARK_SOI      = 8'hD8;
  localparam logic [7:0]       MARK_EOI      = 8'hD9;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd10000000;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_FINAL    = 2'd1,
    KIND_LOST_END = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             last;
  } result_t;

  typedef struct packed {
    logic                 load;
    logic [RES_CNT_W-1:0] cnt;
  } res_ctl_t;

endpackage

// ===== src/jmfe_in_stage.sv =====
`timescale 1ns / 1ps
module jmfe_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  input  logic       consume,
  output logic       byte_v,
  output logic [7:0] byte_d
);

  logic       v_r;
  logic       v_nxt;
  logic [7:0] byte_r;

  assign in_ready = !v_r || consume;
  assign byte_v   = v_r;
  assign byte_d   = byte_r;

  always_comb begin
    v_nxt = v_r;
    if (in_valid && in_ready) begin
      v_nxt = 1'b1;
    end else if (consume) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte_in;
    end
  end

endmodule

// ===== src/jmfe_core.sv =====
`timescale 1ns / 1ps
module jmfe_core
  import jmfe_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             byte_v,
  input  logic [7:0]       byte_d,
  input  logic             buf_free,
  output logic             consume,
  output res_ctl_t         ctl,
  output result_t          res [MAX_RES]
);

  localparam logic [LENGTH_BITS-1:0] CNT_LIMIT = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] CNT_OPEN  = LENGTH_BITS'(2);

  logic [LEN_W-1:0]       max_len_r;
  logic                   in_frame_r;
  logic                   in_frame_nxt;
  logic                   ff_r;
  logic                   ff_nxt;
  logic [LENGTH_BITS-1:0] cnt_r;
  logic [LENGTH_BITS-1:0] cnt_nxt;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic [LEN_W-1:0]       len_cur;
  logic [LEN_W-1:0]       len_inc;
  logic [RES_CNT_W-1:0]   n_new;
  logic                   is_soi;
  logic                   is_eoi;

  assign cnt_inc = (cnt_r == CNT_LIMIT) ? cnt_r : cnt_r + LENGTH_BITS'(1);
  assign len_cur = LEN_W'(cnt_r);
  assign len_inc = LEN_W'(cnt_inc);
  assign is_soi  = ff_r && (byte_d == MARK_SOI);
  assign is_eoi  = ff_r && (byte_d == MARK_EOI);

  always_comb begin
    in_frame_nxt = in_frame_r;
    ff_nxt       = ff_r;
    cnt_nxt      = cnt_r;
    n_new        = RES_CNT_W'(0);
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '{kind: KIND_BYTE, data: 8'h00, len: '0, last: 1'b0};
    end
    if (!in_frame_r) begin
      if (is_soi) begin
        res[0]       = '{kind: KIND_BYTE, data: MARK_FF, len: LEN_W'(1), last: 1'b0};
        res[1]       = '{kind: KIND_BYTE, data: MARK_SOI, len: LEN_W'(2), last: 1'b1};
        n_new        = RES_CNT_W'(2);
        in_frame_nxt = 1'b1;
        ff_nxt       = 1'b0;
        cnt_nxt      = CNT_OPEN;
      end else begin
        ff_nxt = (byte_d == MARK_FF);
      end
    end else if (is_soi) begin
      res[0]  = '{kind: KIND_LOST_END, data: 8'h00, len: len_cur, last: 1'b0};
      res[1]  = '{kind: KIND_BYTE, data: MARK_FF, len: LEN_W'(1), last: 1'b0};
      res[2]  = '{kind: KIND_BYTE, data: MARK_SOI, len: LEN_W'(2), last: 1'b1};
      n_new   = RES_CNT_W'(3);
      ff_nxt  = 1'b0;
      cnt_nxt = CNT_OPEN;
    end else if (is_eoi) begin
      res[0]       = '{kind: KIND_FINAL, data: byte_d, len: len_inc, last: 1'b1};
      n_new        = RES_CNT_W'(1);
      in_frame_nxt = 1'b0;
      ff_nxt       = 1'b0;
      cnt_nxt      = '0;
    end else begin
      ff_nxt = (byte_d == MARK_FF);
      if (len_inc > max_len_r) begin
        res[0]       = '{kind: KIND_BYTE, data: byte_d, len: len_inc, last: 1'b0};
        res[1]       = '{kind: KIND_OVERFLOW, data: 8'h00, len: len_inc, last: 1'b1};
        n_new        = RES_CNT_W'(2);
        in_frame_nxt = 1'b0;
        cnt_nxt      = '0;
      end else begin
        res[0]  = '{kind: KIND_BYTE, data: byte_d, len: len_inc, last: 1'b1};
        n_new   = RES_CNT_W'(1);
        cnt_nxt = cnt_inc;
      end
    end
  end

  // A byte that produces no result may pass even while results are still waiting.
  assign consume  = byte_v && (buf_free || (n_new == RES_CNT_W'(0)));
  assign ctl.load = consume && (n_new != RES_CNT_W'(0));
  assign ctl.cnt  = n_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RESET;
      in_frame_r <= 1'b0;
      ff_r       <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      if (consume) begin
        in_frame_r <= in_frame_nxt;
        ff_r       <= ff_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  a_hunt_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (cnt_r == '0))
    else $error("byte count nonzero while hunting");

endmodule

// ===== src/jmfe_out_buf.sv =====
`timescale 1ns / 1ps
module jmfe_out_buf
  import jmfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  res_ctl_t         ctl,
  input  result_t          res [MAX_RES],
  output logic             buf_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte_out,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_run_last
);

  result_t              slot_r [MAX_RES];
  logic [RES_CNT_W-1:0] n_r;
  logic [RES_CNT_W-1:0] n_nxt;
  logic [RES_IDX_W-1:0] idx_r;
  logic [RES_IDX_W-1:0] idx_nxt;
  logic                 at_last;
  result_t              cur;

  assign out_valid = (n_r != RES_CNT_W'(0));
  assign at_last   = (RES_CNT_W'(idx_r) == n_r - RES_CNT_W'(1));
  assign buf_free  = !out_valid || (out_ready && at_last);

  always_comb begin
    case (idx_r)
      RES_IDX_W'(0): cur = slot_r[0];
      RES_IDX_W'(1): cur = slot_r[1];
      RES_IDX_W'(2): cur = slot_r[2];
      default:       cur = slot_r[0];
    endcase
  end

  assign out_kind         = cur.kind;
  assign out_byte_out     = cur.data;
  assign out_frame_length = cur.len;
  assign out_run_last     = cur.last;

  always_comb begin
    n_nxt   = n_r;
    idx_nxt = idx_r;
    if (ctl.load) begin
      n_nxt   = ctl.cnt;
      idx_nxt = '0;
    end else if (out_valid && out_ready) begin
      if (at_last) begin
        n_nxt   = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      idx_r <= '0;
    end else begin
      n_r   <= n_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        slot_r[i] <= res[i];
      end
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (RES_CNT_W'(idx_r) < n_r))
    else $error("result index beyond loaded count");

  a_load_only_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> buf_free)
    else $error("results loaded over pending results");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_last == at_last))
    else $error("run_last does not match final result of the byte");

endmodule

// ===== src/jpeg_marker_frame_extractor.sv =====
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_byte_in
// out      out_valid / out_ready out_kind, out_byte_out, out_frame_length, out_run_last
// cfg      cfg_we                cfg_wdata (maximum frame length)
//
// A byte is taken every cycle while out_ready is high and each byte yields at most one
// result; a byte that yields two or three results holds the input for as many output
// transfers. The three-slot result register sets this figure: it refills in the cycle
// its last result is taken. Bytes dropped while hunting pass even when results wait.
// Reset is synchronous and active low and sets the maximum length to 10000000.
module jpeg_marker_frame_extractor
  import jmfe_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte_out,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_run_last,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic       consume;
  logic       byte_v;
  logic [7:0] byte_d;
  logic       buf_free;
  res_ctl_t   ctl;
  result_t    res [MAX_RES];

  jmfe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .consume    (consume),
    .byte_v     (byte_v),
    .byte_d     (byte_d)
  );

  jmfe_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .byte_v    (byte_v),
    .byte_d    (byte_d),
    .buf_free  (buf_free),
    .consume   (consume),
    .ctl       (ctl),
    .res       (res)
  );

  jmfe_out_buf u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .res              (res),
    .buf_free         (buf_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_byte_out     (out_byte_out),
    .out_frame_length (out_frame_length),
    .out_run_last     (out_run_last)
  );

endmodule
